[src/fmf_pkg.sv]
// Shared types and constants for the floor mode filter.
package fmf_pkg;

   localparam int WINDOW_DEF = 10;
   localparam int HEIGHT_W = 21;
   localparam int FLOOR_W = 12;
   localparam int FH_W = 15;
   localparam int MINC_W = 4;
   localparam int CNT_OUT_W = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 15;
   localparam int STEP_W = 5;        // covers divide steps and window index up to 31
   localparam int CNT_WIDE_W = 6;    // holds a count up to 32
   localparam int DIV_STEPS = HEIGHT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_HEIGHT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COUNT = 1'd1;

   localparam logic [FH_W-1:0] FLOOR_HEIGHT_RST = 15'd3000;
   localparam logic [MINC_W-1:0] MIN_COUNT_RST = 4'd8;

   localparam logic signed [FLOOR_W-1:0] IDX_MAX = 12'sd2047;
   localparam logic signed [FLOOR_W-1:0] IDX_MIN = -12'sd2047;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_SCAN,
      ST_EMIT
   } fmf_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic scan_step;
      logic emit;
      logic [STEP_W-1:0] step;
   } fmf_cmd_type;

   typedef struct packed {
      logic full_next;
      logic rsp_busy;
   } fmf_status_type;

endpackage

[src/fmf_datapath.sv]
// Datapath: config registers, divider, sample window, mode search and result register.
module fmf_datapath import fmf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [HEIGHT_W-1:0]  req_height_mm,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic signed [FLOOR_W-1:0]   rsp_storey,
   output logic [CNT_OUT_W-1:0]        rsp_mode_count,
   output logic                        rsp_confident,
   input  fmf_cmd_type                 cmd,
   output fmf_status_type              status
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);
   localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(WINDOW - 1);

   logic [FH_W-1:0] floor_height_ff;
   logic [MINC_W-1:0] min_count_ff;

   logic [FH_W-1:0] div_ff, div_in;
   logic neg_ff, neg_in;
   logic [HEIGHT_W-1:0] quo_ff, quo_in;
   logic [FH_W-1:0] rem_ff, rem_in;

   logic signed [FLOOR_W-1:0] win_ff [WINDOW];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] wpos_ff, wpos_in;

   logic signed [FLOOR_W-1:0] best_val_ff, best_val_in;
   logic [CNT_W-1:0] best_cnt_ff, best_cnt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [FLOOR_W-1:0] rsp_floor_ff, rsp_floor_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic rsp_conf_ff, rsp_conf_in;

   logic [HEIGHT_W:0] neg_ext;
   logic [FH_W:0] shifted;
   logic [FH_W+1:0] diff;
   logic [HEIGHT_W:0] pos_q;
   logic signed [FLOOR_W-1:0] new_idx;
   logic signed [FLOOR_W-1:0] cand;
   logic [CNT_W-1:0] cand_cnt;
   logic [CNT_WIDE_W-1:0] best_wide;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_height_ff <= FLOOR_HEIGHT_RST;
         min_count_ff <= MIN_COUNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FLOOR_HEIGHT: floor_height_ff <= csr_wdata[FH_W-1:0];
            CSR_MIN_COUNT:    min_count_ff <= csr_wdata[MINC_W-1:0];
            default: ;
         endcase
      end
   end

   // divider: one quotient bit per step on the magnitude
   always_comb begin
      neg_ext = (HEIGHT_W+1)'(0) - {req_height_mm[HEIGHT_W-1], req_height_mm};
      shifted = {rem_ff, quo_ff[HEIGHT_W-1]};
      diff = {1'b0, shifted} - {2'b00, div_ff};
      div_in = div_ff;
      neg_in = neg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         div_in = (floor_height_ff == '0) ? FH_W'(1) : floor_height_ff;
         neg_in = req_height_mm[HEIGHT_W-1];
         quo_in = req_height_mm[HEIGHT_W-1] ? neg_ext[HEIGHT_W-1:0] : req_height_mm;
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (!diff[FH_W+1]) begin
            rem_in = diff[FH_W-1:0];
            quo_in = {quo_ff[HEIGHT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[FH_W-1:0];
            quo_in = {quo_ff[HEIGHT_W-2:0], 1'b0};
         end
      end
   end

   // round toward plus infinity, then saturate
   always_comb begin
      pos_q = {1'b0, quo_ff} + (HEIGHT_W+1)'(rem_ff != '0);
      if (neg_ff) begin
         if (quo_ff > HEIGHT_W'(2047)) new_idx = IDX_MIN;
         else new_idx = FLOOR_W'(0) - quo_ff[FLOOR_W-1:0];
      end else begin
         if (pos_q > (HEIGHT_W+1)'(2047)) new_idx = IDX_MAX;
         else new_idx = pos_q[FLOOR_W-1:0];
      end
   end

   // count how often the candidate occurs in the window
   always_comb begin
      cand = win_ff[cmd.step[IDX_W-1:0]];
      cand_cnt = '0;
      for (int j = 0; j < WINDOW; j++) begin
         cand_cnt = cand_cnt + CNT_W'(win_ff[j] == cand);
      end
   end

   always_comb begin
      fill_in = fill_ff;
      wpos_in = wpos_ff;
      best_val_in = best_val_ff;
      best_cnt_in = best_cnt_ff;
      if (cmd.store) begin
         if (fill_ff != FULL_CNT) fill_in = fill_ff + CNT_W'(1);
         wpos_in = (wpos_ff == POS_LAST) ? '0 : wpos_ff + IDX_W'(1);
         best_cnt_in = '0;
         best_val_in = '0;
      end else if (cmd.scan_step) begin
         if (cand_cnt > best_cnt_ff || (cand_cnt == best_cnt_ff && cand < best_val_ff)) begin
            best_cnt_in = cand_cnt;
            best_val_in = cand;
         end
      end
   end

   // result register
   always_comb begin
      best_wide = CNT_WIDE_W'(best_cnt_ff);
      rsp_valid_in = rsp_valid_ff;
      rsp_floor_in = rsp_floor_ff;
      rsp_cnt_in = rsp_cnt_ff;
      rsp_conf_in = rsp_conf_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_floor_in = (best_val_ff < FLOOR_W'(1)) ? best_val_ff - FLOOR_W'(1) : best_val_ff;
         rsp_cnt_in = (best_wide > CNT_WIDE_W'(15)) ? CNT_OUT_W'(15) : best_wide[CNT_OUT_W-1:0];
         rsp_conf_in = best_wide >= CNT_WIDE_W'(min_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wpos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         wpos_ff <= wpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      best_val_ff <= best_val_in;
      best_cnt_ff <= best_cnt_in;
      rsp_floor_ff <= rsp_floor_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_conf_ff <= rsp_conf_in;
      if (cmd.store) win_ff[wpos_ff] <= new_idx;
   end

   assign status.full_next = (fill_ff >= FILL_LAST);
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_storey = rsp_floor_ff;
   assign rsp_mode_count = rsp_cnt_ff;
   assign rsp_confident = rsp_conf_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT) else $error("fill count beyond window");

   a_wpos_bound: assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= POS_LAST) else $error("write position beyond window");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff) else $error("emitted beat not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.rsp_busy) else $error("pending beat overwritten");

endmodule

[src/fmf_ctrl.sv]
// Controller: sequences load, divide, store, mode scan and result hand-off.
module fmf_ctrl import fmf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  fmf_status_type  status,
   output fmf_cmd_type     cmd
);

   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
   localparam logic [STEP_W-1:0] SCAN_LAST = STEP_W'(WINDOW - 1);

   fmf_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == DIV_LAST) state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            step_in = '0;
            // drop the result while the window is still filling
            state_in = status.full_next ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == SCAN_LAST) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[src/floor_mode_filter_unit.sv]
// Top level of the floor mode filter: controller plus datapath.
// Each req beat carries one height in mm; it is divided by the configured floor height
// (rounded up, saturated to +/-2047) and pushed into a window of the last WINDOW floor
// indices. From the WINDOW-th beat on, every beat yields one rsp beat with the window
// mode (ties to the smaller index, lowered by one below 1), its count and a confidence
// flag. An item passes through an accept step, the bit-serial divider (one quotient bit
// per step), a store step, a mode scan over every window entry and a hand-off into the
// result register, which lets the next beat be accepted while a result waits; while the
// window fills, the scan and hand-off are skipped. The hand-off stretches for as long as
// the previous result is still waiting for rsp_ready. The user must make CSR writes only
// while the block is idle; the block itself does not enforce this.
module floor_mode_filter_unit import fmf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [HEIGHT_W-1:0]  req_height_mm,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [FLOOR_W-1:0]   rsp_storey,
   output logic [CNT_OUT_W-1:0]        rsp_mode_count,
   output logic                        rsp_confident
);

   fmf_cmd_type cmd;
   fmf_status_type status;

   fmf_ctrl #(.WINDOW(WINDOW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fmf_datapath #(.WINDOW(WINDOW)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_height_mm    (req_height_mm),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_storey       (rsp_storey),
      .rsp_mode_count   (rsp_mode_count),
      .rsp_confident    (rsp_confident),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
